@@ rtl/core/atstm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package atstm_pkg;

  localparam logic [1:0] TILE_CLAMP  = 2'd0;
  localparam logic [1:0] TILE_REPEAT = 2'd1;
  localparam logic [1:0] TILE_MIRROR = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SPAN  = 1'b1;

  localparam logic [2:0] REG_INV_XX = 3'd0;
  localparam logic [2:0] REG_INV_XY = 3'd1;
  localparam logic [2:0] REG_INV_XT = 3'd2;
  localparam logic [2:0] REG_INV_YX = 3'd3;
  localparam logic [2:0] REG_INV_YY = 3'd4;
  localparam logic [2:0] REG_INV_YT = 3'd5;
  localparam logic [2:0] REG_TILE   = 3'd6;
  localparam logic [2:0] REG_DIMS   = 3'd7;

  localparam int DimW = 9;

  typedef struct packed {
    logic             done;
    logic [DimW-1:0]  rem;
    logic             q_odd;
  } div_res_t;

endpackage
`default_nettype wire

@@ rtl/core/atstm_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface atstm_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [11:0] dest_x;
  logic [11:0] dest_y;
  logic [6:0]  span_count;
  logic [15:0] texel_addr;
  logic [31:0] texel_value;

  modport source (output valid, opcode, dest_x, dest_y, span_count, texel_addr,
                  texel_value, input ready);
  modport sink (input valid, opcode, dest_x, dest_y, span_count, texel_addr,
                texel_value, output ready);
endinterface
`default_nettype wire

@@ rtl/core/atstm_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface atstm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel;
  logic        last_of_span;

  modport source (output valid, pixel, last_of_span, input ready);
  modport sink (input valid, pixel, last_of_span, output ready);
endinterface
`default_nettype wire

@@ rtl/core/atstm_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// remainder and quotient parity of floor division of a signed integer by n, one bit per cycle
module atstm_div (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       start_i,
  input  wire  [31:0]               value_i,
  input  wire  [atstm_pkg::DimW-1:0] n_i,
  output atstm_pkg::div_res_t       res_o
);
  localparam int W = atstm_pkg::DimW;

  logic          busy_q, done_q, neg_q, qlsb_q;
  logic [4:0]    cnt_q;
  logic [30:0]   dvd_q;
  logic [W-1:0]  rem_q, n_q;
  logic [W:0]    trial;
  logic          fits;

  assign trial = {rem_q, dvd_q[30]};
  assign fits  = trial >= {1'b0, n_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == 5'd30);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd30) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q  <= value_i[31];
      dvd_q  <= value_i[31] ? ~value_i[30:0] : value_i[30:0];
      n_q    <= n_i;
      rem_q  <= '0;
      qlsb_q <= 1'b0;
    end else if (busy_q) begin
      dvd_q  <= {dvd_q[29:0], 1'b0};
      rem_q  <= fits ? W'(trial - {1'b0, n_q}) : trial[W-1:0];
      qlsb_q <= fits;
    end
  end

  assign res_o.done  = done_q;
  assign res_o.rem   = neg_q ? W'(n_q - rem_q - 1'b1) : rem_q;
  assign res_o.q_odd = neg_q ? ~qlsb_q : qlsb_q;
endmodule
`default_nettype wire

@@ rtl/core/affine_texture_sampler_tile_modes.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  word
// req_i     in   opcode, dest_x, dest_y, span_count, texel_addr, texel_value
// rsp_o     out  pixel, last_of_span
// cfg_*     in   register write, index and data
//
// Texel write: written on acceptance. Span: setup in INIT1 and INIT2, then per pixel
// START, ADDR, READ; repeat/mirror mode runs the bit-serial divider in DIV after START.
// Texture memory is not cleared by reset; reset restores registers and control.
// A pixel waits for the output register; a pending word does not block input.
module affine_texture_sampler_tile_modes #(
  parameter int TEX_MAX_WIDTH  = 256,
  parameter int TEX_MAX_HEIGHT = 256,
  parameter int MAX_SPAN       = 64
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  wire [2:0]  cfg_idx_i,
  input  wire [31:0] cfg_data_i,
  atstm_in_if.sink   req_i,
  atstm_out_if.source rsp_o
);
  localparam int DW    = atstm_pkg::DimW;
  localparam int DEPTH = TEX_MAX_WIDTH * TEX_MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [DW-1:0] WMAX = (TEX_MAX_WIDTH > 511) ? 9'd511 : DW'(TEX_MAX_WIDTH);
  localparam logic [DW-1:0] HMAX = (TEX_MAX_HEIGHT > 511) ? 9'd511 : DW'(TEX_MAX_HEIGHT);
  localparam logic [6:0] NMAX = 7'(MAX_SPAN);

  typedef enum logic [2:0] {S_IDLE, S_INIT1, S_INIT2, S_START, S_DIV, S_ADDR, S_READ} state_e;

  logic signed [31:0] inv_xx_q, inv_xy_q, inv_xt_q, inv_yx_q, inv_yy_q, inv_yt_q;
  logic [1:0]  tile_q;
  logic [17:0] dims_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_xx_q <= 32'sd65536;
      inv_xy_q <= '0;
      inv_xt_q <= '0;
      inv_yx_q <= '0;
      inv_yy_q <= 32'sd65536;
      inv_yt_q <= '0;
      tile_q   <= atstm_pkg::TILE_CLAMP;
      dims_q   <= 18'd131328;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        atstm_pkg::REG_INV_XX: inv_xx_q <= cfg_data_i;
        atstm_pkg::REG_INV_XY: inv_xy_q <= cfg_data_i;
        atstm_pkg::REG_INV_XT: inv_xt_q <= cfg_data_i;
        atstm_pkg::REG_INV_YX: inv_yx_q <= cfg_data_i;
        atstm_pkg::REG_INV_YY: inv_yy_q <= cfg_data_i;
        atstm_pkg::REG_INV_YT: inv_yt_q <= cfg_data_i;
        atstm_pkg::REG_TILE:   tile_q   <= cfg_data_i[1:0];
        atstm_pkg::REG_DIMS:   dims_q   <= cfg_data_i[17:0];
        default: ;
      endcase
    end
  end

  logic [DW-1:0] w, h;
  always_comb begin
    w = dims_q[8:0];
    h = dims_q[17:9];
    if (w == '0) w = 9'd1;
    if (h == '0) h = 9'd1;
    if (w > WMAX) w = WMAX;
    if (h > HMAX) h = HMAX;
  end

  state_e state_q;
  logic [6:0]  left_q;
  logic [11:0] dx_q, dy_q;
  logic signed [60:0] mxx_q, mxy_q, myx_q, myy_q;
  logic signed [63:0] sx_q, sy_q;
  logic        out_valid_q, out_last_q;
  logic [31:0] out_pix_q;
  logic        last_pend_q;

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;

  logic        accept, div_start, is_clamp, rd_en, out_load;
  logic [6:0]  cnt_sat;
  logic [AW-1:0] rd_addr;
  atstm_pkg::div_res_t dx_res, dy_res;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign cnt_sat     = (req_i.span_count > NMAX) ? NMAX : req_i.span_count;
  assign is_clamp    = !(tile_q == atstm_pkg::TILE_REPEAT || tile_q == atstm_pkg::TILE_MIRROR);
  assign div_start   = (state_q == S_START) && !is_clamp;
  assign rd_en       = (state_q == S_ADDR);
  assign out_load    = (state_q == S_READ) && (!out_valid_q || rsp_o.ready);

  atstm_div u_div_x (
    .clk_i, .rst_ni, .start_i(div_start), .value_i(sx_q[63:32]), .n_i(w), .res_o(dx_res)
  );
  atstm_div u_div_y (
    .clk_i, .rst_ni, .start_i(div_start), .value_i(sy_q[63:32]), .n_i(h), .res_o(dy_res)
  );

  function automatic logic [DW-1:0] tile_idx(input logic [1:0] mode,
                                             input logic [63:0] s,
                                             input logic [DW-1:0] n,
                                             input logic [DW-1:0] rem,
                                             input logic q_odd);
    logic signed [33:0] cc;
    logic [DW:0]        c;
    logic [31:0]        nf;
    begin
      cc = '0;
      nf = 32'd0 - s[31:0];
      if (mode == atstm_pkg::TILE_REPEAT ||
          (mode == atstm_pkg::TILE_MIRROR && !q_odd)) begin
        c = {1'b0, rem} + (DW+1)'(s[31]);
      end else if (mode == atstm_pkg::TILE_MIRROR) begin
        c = {1'b0, n} - {1'b0, rem} - (DW+1)'(s[31:0] != 32'd0) + (DW+1)'(nf[31]);
      end else begin
        cc = $signed({s[63], s[63:32]}) + $signed({33'd0, s[31]});
        if (cc < 0) c = '0;
        else if (cc > $signed({25'd0, n} - 34'sd1)) c = {1'b0, n} - 1'b1;
        else c = cc[DW:0];
      end
      if (c > {1'b0, n} - 1'b1) c = {1'b0, n} - 1'b1;
      return c[DW-1:0];
    end
  endfunction

  logic [DW-1:0] cx, cy;
  assign cx = tile_idx(tile_q, sx_q, w, dx_res.rem, dx_res.q_odd);
  assign cy = tile_idx(tile_q, sy_q, h, dy_res.rem, dy_res.q_odd);
  assign rd_addr = AW'(AW'(cy) * AW'(TEX_MAX_WIDTH) + AW'(cx));

  always_ff @(posedge clk_i) begin
    if (accept && req_i.opcode == atstm_pkg::OP_WRITE &&
        32'(req_i.texel_addr) < DEPTH)
      mem[AW'(req_i.texel_addr)] <= req_i.texel_value;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dx_q <= req_i.dest_x;
      dy_q <= req_i.dest_y;
    end
    if (state_q == S_INIT1) begin
      mxx_q <= inv_xx_q * $signed({1'b0, dx_q, 16'h8000});
      myx_q <= inv_yx_q * $signed({1'b0, dx_q, 16'h8000});
      mxy_q <= inv_xy_q * $signed({1'b0, dy_q, 16'h8000});
      myy_q <= inv_yy_q * $signed({1'b0, dy_q, 16'h8000});
    end
    if (state_q == S_INIT2) begin
      sx_q <= 64'(mxx_q) + 64'(mxy_q) + {{16{inv_xt_q[31]}}, inv_xt_q, 16'd0};
      sy_q <= 64'(myx_q) + 64'(myy_q) + {{16{inv_yt_q[31]}}, inv_yt_q, 16'd0};
    end else if (state_q == S_READ && (!out_valid_q || rsp_o.ready)) begin
      sx_q <= sx_q + {{16{inv_xx_q[31]}}, inv_xx_q, 16'd0};
      sy_q <= sy_q + {{16{inv_yx_q[31]}}, inv_yx_q, 16'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      left_q      <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_pix_q   <= '0;
      last_pend_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept && req_i.opcode == atstm_pkg::OP_SPAN && cnt_sat != '0) begin
            left_q  <= cnt_sat;
            state_q <= S_INIT1;
          end
        end
        S_INIT1: state_q <= S_INIT2;
        S_INIT2: state_q <= S_START;
        S_START: state_q <= is_clamp ? S_ADDR : S_DIV;
        S_DIV:   if (dx_res.done) state_q <= S_ADDR;
        S_ADDR: begin
          last_pend_q <= (left_q == 7'd1);
          state_q     <= S_READ;
        end
        S_READ: begin
          if (out_load) begin
            out_pix_q   <= rdata_q;
            out_last_q  <= last_pend_q;
            left_q      <= left_q - 7'd1;
            state_q     <= last_pend_q ? S_IDLE : S_START;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.pixel        = out_pix_q;
  assign rsp_o.last_of_span = out_last_q;
endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    logic        opcode;
    logic [11:0] dest_x;
    logic [11:0] dest_y;
    logic [6:0]  span_count;
    logic [15:0] texel_addr;
    logic [31:0] texel_value;
  } req_word_t;

  typedef struct {
    logic [31:0] pixel;
    logic        last;
  } pixel_word_t;

  localparam int ItemTarget = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  atstm_in_if  req ();
  atstm_out_if rsp ();

  affine_texture_sampler_tile_modes dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req),
    .rsp_o      (rsp)
  );

  // register shadow
  int          m_xx, m_xy, m_xt, m_yx, m_yy, m_yt;
  logic [1:0]  tile_sh;
  logic [17:0] dims_sh;

  logic [31:0] tex_mem [65536];
  bit          tex_written [65536];

  req_word_t   pending_words[$];
  pixel_word_t pixel_queue[$];
  req_word_t   cur;
  int          burst_left;
  int          gap_left;
  int          stall_mode;
  int          stall_left;
  int          n_items;
  bit          failed;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int eff_dim(logic [8:0] v);
    if (v == 9'd0) return 1;
    if (v > 9'd256) return 256;
    return int'(v);
  endfunction

  function automatic int tile_index(longint s, int n);
    longint period, q, r, c;
    period = longint'(n) <<< 32;
    if (tile_sh == atstm_pkg::TILE_REPEAT || tile_sh == atstm_pkg::TILE_MIRROR) begin
      q = s / period;
      r = s % period;
      if (r < 0) begin
        r += period;
        q -= 1;
      end
      if (tile_sh == atstm_pkg::TILE_MIRROR && q[0]) r = period - r;
      s = r;
    end
    c = (s + 64'sh80000000) >>> 32;
    if (c < 0) c = 0;
    if (c > n - 1) c = n - 1;
    return int'(c);
  endfunction

  function automatic logic [15:0] sample_addr(logic [11:0] dx, logic [11:0] dy, int i);
    longint px, py, sx, sy;
    int cx, cy;
    py = longint'(dy) * 65536 + 32768;
    px = (longint'(dx) + i) * 65536 + 32768;
    sx = longint'(m_xx) * px + longint'(m_xy) * py + longint'(m_xt) * 65536;
    sy = longint'(m_yx) * px + longint'(m_yy) * py + longint'(m_yt) * 65536;
    cx = tile_index(sx, eff_dim(dims_sh[8:0]));
    cy = tile_index(sy, eff_dim(dims_sh[17:9]));
    return 16'(cy * 256 + cx);
  endfunction

  function automatic int eff_count(logic [6:0] c);
    return (c > 7'd64) ? 64 : int'(c);
  endfunction

  function automatic void shade_span(req_word_t w);
    int n;
    pixel_word_t p;
    if (w.opcode == atstm_pkg::OP_WRITE) begin
      tex_mem[w.texel_addr] = w.texel_value;
      return;
    end
    n = eff_count(w.span_count);
    for (int i = 0; i < n; i++) begin
      p.pixel = tex_mem[sample_addr(w.dest_x, w.dest_y, i)];
      p.last  = (i == n - 1);
      pixel_queue.push_back(p);
    end
  endfunction

  // queues a word; spans get any texel they touch written first
  task automatic push_word(req_word_t w);
    req_word_t t;
    logic [15:0] a;
    if (w.opcode == atstm_pkg::OP_SPAN) begin
      for (int i = 0; i < eff_count(w.span_count); i++) begin
        a = sample_addr(w.dest_x, w.dest_y, i);
        if (!tex_written[a]) begin
          t = w;
          t.opcode = atstm_pkg::OP_WRITE;
          t.texel_addr = a;
          t.texel_value = $urandom;
          tex_written[a] = 1'b1;
          pending_words.push_back(t);
          n_items++;
        end
      end
    end else begin
      tex_written[w.texel_addr] = 1'b1;
    end
    pending_words.push_back(w);
    n_items++;
  endtask

  task automatic push_span(logic [11:0] dx, logic [11:0] dy, logic [6:0] cnt);
    req_word_t w;
    w.opcode = atstm_pkg::OP_SPAN;
    w.dest_x = dx;
    w.dest_y = dy;
    w.span_count = cnt;
    w.texel_addr = $urandom;
    w.texel_value = $urandom;
    push_word(w);
  endtask

  task automatic push_write(logic [15:0] a, logic [31:0] v);
    req_word_t w;
    w.opcode = atstm_pkg::OP_WRITE;
    w.dest_x = $urandom;
    w.dest_y = $urandom;
    w.span_count = $urandom;
    w.texel_addr = a;
    w.texel_value = v;
    push_word(w);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      atstm_pkg::REG_INV_XX: m_xx = data;
      atstm_pkg::REG_INV_XY: m_xy = data;
      atstm_pkg::REG_INV_XT: m_xt = data;
      atstm_pkg::REG_INV_YX: m_yx = data;
      atstm_pkg::REG_INV_YY: m_yy = data;
      atstm_pkg::REG_INV_YT: m_yt = data;
      atstm_pkg::REG_TILE:   tile_sh = data[1:0];
      atstm_pkg::REG_DIMS:   dims_sh = data[17:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || req.valid || pixel_queue.size() != 0)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coef();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = 32'h8000_0000;
      2: v = 32'h7fff_ffff;
      3: v = 32'd0;
      default: begin
        v = $urandom_range(0, 32'h0004_0000);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [17:0] rand_dims();
    case ($urandom_range(0, 4))
      0: return 18'($urandom);
      1: return {9'd256, 9'd256};
      default: return {9'($urandom_range(1, 16)), 9'($urandom_range(1, 16))};
    endcase
  endfunction

  task automatic set_all(logic [31:0] xx, logic [31:0] xy, logic [31:0] xt,
                         logic [31:0] yx, logic [31:0] yy, logic [31:0] yt,
                         logic [1:0] tm, logic [17:0] dm);
    write_reg(atstm_pkg::REG_INV_XX, xx);
    write_reg(atstm_pkg::REG_INV_XY, xy);
    write_reg(atstm_pkg::REG_INV_XT, xt);
    write_reg(atstm_pkg::REG_INV_YX, yx);
    write_reg(atstm_pkg::REG_INV_YY, yy);
    write_reg(atstm_pkg::REG_INV_YT, yt);
    write_reg(atstm_pkg::REG_TILE, {30'd0, tm});
    write_reg(atstm_pkg::REG_DIMS, {14'd0, dm});
  endtask

  task automatic random_words(int cnt);
    logic [6:0] c;
    for (int k = 0; k < cnt && n_items < ItemTarget; k++) begin
      if ($urandom_range(0, 9) < 3) begin
        push_write($urandom, $urandom);
      end else begin
        case ($urandom_range(0, 19))
          0:       c = $urandom;
          1, 2, 3: c = $urandom_range(9, 64);
          default: c = $urandom_range(1, 8);
        endcase
        push_span($urandom, $urandom, c);
      end
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    logic fire;
    fire = req.valid && req.ready;
    if (rst_ni) begin
      if (fire) shade_span(cur);
      if (!req.valid || fire) begin
        if (gap_left > 0) begin
          gap_left--;
          req.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          cur = pending_words.pop_front();
          req.opcode      <= cur.opcode;
          req.dest_x      <= cur.dest_x;
          req.dest_y      <= cur.dest_y;
          req.span_count  <= cur.span_count;
          req.texel_addr  <= cur.texel_addr;
          req.texel_value <= cur.texel_value;
          req.valid       <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    pixel_word_t e;
    if (rst_ni) begin
      if (rsp.valid && rsp.ready) begin
        if (pixel_queue.size() == 0) begin
          $error("unexpected word: pixel %h last %b", rsp.pixel, rsp.last_of_span);
          failed = 1'b1;
        end else begin
          e = pixel_queue.pop_front();
          if (rsp.pixel !== e.pixel) begin
            $error("pixel: expected %h, got %h", e.pixel, rsp.pixel);
            failed = 1'b1;
          end
          if (rsp.last_of_span !== e.last) begin
            $error("last_of_span: expected %b, got %b", e.last, rsp.last_of_span);
            failed = 1'b1;
          end
        end
      end
      stall_left--;
      if (stall_left <= 0) begin
        stall_left = $urandom_range(8, 80);
        stall_mode = $urandom_range(0, 2);
      end
      case (stall_mode)
        0:       rsp.ready <= 1'b1;
        1:       rsp.ready <= $urandom_range(0, 1);
        default: rsp.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    req.valid = 1'b0;
    req.opcode = atstm_pkg::OP_WRITE;
    req.dest_x = '0;
    req.dest_y = '0;
    req.span_count = '0;
    req.texel_addr = '0;
    req.texel_value = '0;
    rsp.ready = 1'b0;
    failed = 1'b0;
    burst_left = 1;
    gap_left = 0;
    stall_mode = 0;
    stall_left = 0;
    n_items = 0;
    m_xx = 65536; m_xy = 0; m_xt = 0;
    m_yx = 0; m_yy = 65536; m_yt = 0;
    tile_sh = atstm_pkg::TILE_CLAMP;
    dims_sh = 18'd131328;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset settings
    push_write(16'h0000, 32'h0000_0000);
    push_write(16'hffff, 32'hffff_ffff);
    push_span(12'd0, 12'd0, 7'd1);
    push_span(12'hfff, 12'hfff, 7'd64);
    push_span(12'd0, 12'hfff, 7'd0);
    push_span(12'hfc0, 12'd0, 7'd127);
    push_span(12'd250, 12'd255, 7'd8);
    wait_idle();
    set_all(32'h0001_8000, 32'h0000_4000, 32'hfffe_0000, 32'hffff_c000, 32'h0000_c000,
            32'h0003_0000, atstm_pkg::TILE_REPEAT, {9'd5, 9'd7});
    push_span(12'd0, 12'd0, 7'd20);
    push_span(12'd4000, 12'd3, 7'd64);
    wait_idle();
    write_reg(atstm_pkg::REG_TILE, {30'd0, atstm_pkg::TILE_MIRROR});
    push_span(12'd0, 12'd0, 7'd30);
    push_span(12'd123, 12'd4095, 7'd16);
    wait_idle();
    write_reg(atstm_pkg::REG_TILE, 32'd3);
    write_reg(atstm_pkg::REG_DIMS, 32'd0);
    push_span(12'd7, 12'd9, 7'd4);
    wait_idle();
    write_reg(atstm_pkg::REG_DIMS, 32'h3ffff);
    push_span(12'd17, 12'd900, 7'd10);
    wait_idle();
    set_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, atstm_pkg::TILE_MIRROR, {9'd256, 9'd256});
    push_span(12'hfff, 12'hfff, 7'd6);
    push_span(12'd0, 12'd0, 7'd6);
    wait_idle();
    set_all(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
            32'h7fff_ffff, atstm_pkg::TILE_REPEAT, {9'd1, 9'd1});
    push_span(12'hfff, 12'hfff, 7'd6);
    push_span(12'd0, 12'd0, 7'd6);

    while (n_items < ItemTarget) begin
      wait_idle();
      set_all(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
              rand_coef(), 2'($urandom_range(0, 3)), rand_dims());
      random_words(30);
    end

    wait_idle();
    repeat (100) @(posedge clk_i);
    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
